@@ hw/rtl/ifmt_pkg.sv @@
// Package for the integer to ASCII formatter: payload structs, microcode
// encoding, the control program ROM and the digit character table.
// No dependencies.
package ifmt_pkg;

  // width of the value printed in pointer mode, 32..64
  localparam int PTR_BITS = 64;
  localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - PTR_BITS);

  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_X    = 8'h78;

  localparam int HEX_DIGITS_PTR = 16;
  localparam int HEX_DIGITS_32  = 8;
  localparam int DEC_DIGITS     = 10;
  localparam int DAB_STEPS      = 32;

  typedef logic [4:0] dcnt_t;   // digits left in the shift register
  typedef logic [4:0] bcnt_t;   // double-dabble bit counter

  typedef enum logic [1:0] {
    OP_PTR  = 2'd0,
    OP_LHEX = 2'd1,
    OP_UHEX = 2'd2,
    OP_DEC  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  character;
    logic        last_char;
    logic [31:0] running_count;
  } out_item_t;

  // program step addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_WAIT   = 4'd0;
  localparam step_t ST_DISP   = 4'd1;
  localparam step_t ST_PFX0   = 4'd2;
  localparam step_t ST_PFXX   = 4'd3;
  localparam step_t ST_DECCHK = 4'd4;
  localparam step_t ST_DAB    = 4'd5;
  localparam step_t ST_COPY   = 4'd6;
  localparam step_t ST_SKIP   = 4'd7;
  localparam step_t ST_EMIT   = 4'd8;
  localparam step_t ST_DONE   = 4'd9;

  typedef enum logic [2:0] {
    A_NOP,
    A_LOAD,
    A_EMIT_ZERO,
    A_EMIT_X,
    A_DAB,
    A_COPY,
    A_SKIP,
    A_EMIT_DIG
  } act_t;

  // jump conditions; C_NEXT never jumps
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_NOT_PTR,
    C_NOT_DEC,
    C_BC_NZ,
    C_LEADZ,
    C_MORE
  } cond_t;

  typedef struct packed {
    logic  take;
    act_t  act;
    cond_t cond;
    step_t target;
  } cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic is_ptr;
    logic is_dec;
    logic bc_nz;
    logic lead_zero;
    logic more;
    logic emit_ok;
  } stat_t;

  function automatic cw_t ucode(input step_t s);
    cw_t w;
    unique case (s)
      ST_WAIT:   w = '{take: 1'b1, act: A_LOAD,      cond: C_NO_IN,   target: ST_WAIT};
      ST_DISP:   w = '{take: 1'b0, act: A_NOP,       cond: C_NOT_PTR, target: ST_DECCHK};
      ST_PFX0:   w = '{take: 1'b0, act: A_EMIT_ZERO, cond: C_NEXT,    target: ST_WAIT};
      ST_PFXX:   w = '{take: 1'b0, act: A_EMIT_X,    cond: C_NEXT,    target: ST_WAIT};
      ST_DECCHK: w = '{take: 1'b0, act: A_NOP,       cond: C_NOT_DEC, target: ST_SKIP};
      ST_DAB:    w = '{take: 1'b0, act: A_DAB,       cond: C_BC_NZ,   target: ST_DAB};
      ST_COPY:   w = '{take: 1'b0, act: A_COPY,      cond: C_NEXT,    target: ST_WAIT};
      ST_SKIP:   w = '{take: 1'b0, act: A_SKIP,      cond: C_LEADZ,   target: ST_SKIP};
      ST_EMIT:   w = '{take: 1'b0, act: A_EMIT_DIG,  cond: C_MORE,    target: ST_EMIT};
      default:   w = '{take: 1'b0, act: A_NOP,       cond: C_ALWAYS,  target: ST_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHR_ZERO + {4'd0, nib};
    end else if (upper) begin
      c = 8'h41 + {4'd0, nib - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/ifmt_seq.sv @@
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on ifmt_pkg.
module ifmt_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  ifmt_pkg::stat_t stat,
  output ifmt_pkg::cw_t  cw
);
  import ifmt_pkg::*;

  step_t step_r, step_nxt;
  logic  jump;
  logic  hold;

  assign cw = ucode(step_r);

  // emit steps wait for room in the output register
  assign hold = ((cw.act == A_EMIT_ZERO) || (cw.act == A_EMIT_X) ||
                 (cw.act == A_EMIT_DIG)) && !stat.emit_ok;

  always_comb begin
    unique case (cw.cond)
      C_NEXT:    jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_NO_IN:   jump = !in_valid;
      C_NOT_PTR: jump = !stat.is_ptr;
      C_NOT_DEC: jump = !stat.is_dec;
      C_BC_NZ:   jump = stat.bc_nz;
      C_LEADZ:   jump = stat.lead_zero;
      C_MORE:    jump = stat.more;
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ hw/rtl/ifmt_dp.sv @@
// Formatter datapath: digit shift register, double-dabble converter,
// output register and saturating character counter. Depends on ifmt_pkg.
module ifmt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ifmt_pkg::cw_t       cw,
  input  logic                accept,
  input  ifmt_pkg::in_item_t  in_item,
  input  logic                out_stall,
  output ifmt_pkg::stat_t     stat,
  output logic                out_valid,
  output ifmt_pkg::out_item_t out_item
);
  import ifmt_pkg::*;

  logic [63:0] dig_r, dig_nxt;
  dcnt_t       dcnt_r, dcnt_nxt;
  logic [31:0] bin_r, bin_nxt;
  logic [39:0] bcd_r, bcd_nxt;
  bcnt_t       bcnt_r, bcnt_nxt;
  logic        is_ptr_r, is_ptr_nxt;
  logic        is_dec_r, is_dec_nxt;
  logic        upper_r, upper_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic [31:0] rcnt_r, rcnt_nxt;

  logic        emit_ok;
  logic        do_emit;
  logic        lead_zero;
  logic [7:0]  emit_chr;
  logic [39:0] bcd_adj;

  assign emit_ok   = !out_valid_r || !out_stall;
  assign do_emit   = emit_ok && ((cw.act == A_EMIT_ZERO) || (cw.act == A_EMIT_X) ||
                                 (cw.act == A_EMIT_DIG));
  assign lead_zero = (dig_r[63:60] == 4'd0) && (dcnt_r > dcnt_t'(1));

  assign stat.is_ptr    = is_ptr_r;
  assign stat.is_dec    = is_dec_r;
  assign stat.bc_nz     = (bcnt_r != bcnt_t'(0));
  assign stat.lead_zero = lead_zero;
  assign stat.more      = (dcnt_r != dcnt_t'(1));
  assign stat.emit_ok   = emit_ok;

  // add 3 to every BCD digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    case (cw.act)
      A_EMIT_ZERO: emit_chr = CHR_ZERO;
      A_EMIT_X:    emit_chr = CHR_X;
      default:     emit_chr = digit_char(dig_r[63:60], upper_r);
    endcase
  end

  always_comb begin
    dig_nxt    = dig_r;
    dcnt_nxt   = dcnt_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    bcnt_nxt   = bcnt_r;
    is_ptr_nxt = is_ptr_r;
    is_dec_nxt = is_dec_r;
    upper_nxt  = upper_r;
    if (accept) begin
      is_ptr_nxt = (in_item.op == OP_PTR);
      is_dec_nxt = (in_item.op == OP_DEC);
      upper_nxt  = (in_item.op == OP_UHEX);
      bin_nxt    = in_item.value[31:0];
      bcd_nxt    = '0;
      bcnt_nxt   = bcnt_t'(DAB_STEPS - 1);
      if (in_item.op == OP_PTR) begin
        dig_nxt  = in_item.value & PTR_MASK;
        dcnt_nxt = dcnt_t'(HEX_DIGITS_PTR);
      end else begin
        dig_nxt  = {in_item.value[31:0], 32'd0};
        dcnt_nxt = dcnt_t'(HEX_DIGITS_32);
      end
    end else begin
      case (cw.act)
        A_DAB: begin
          bcd_nxt  = {bcd_adj[38:0], bin_r[31]};
          bin_nxt  = {bin_r[30:0], 1'b0};
          bcnt_nxt = bcnt_r - bcnt_t'(1);
        end
        A_COPY: begin
          dig_nxt  = {bcd_r, 24'd0};
          dcnt_nxt = dcnt_t'(DEC_DIGITS);
        end
        A_SKIP: begin
          if (lead_zero) begin
            dig_nxt  = {dig_r[59:0], 4'd0};
            dcnt_nxt = dcnt_r - dcnt_t'(1);
          end
        end
        A_EMIT_DIG: begin
          if (emit_ok) begin
            dig_nxt  = {dig_r[59:0], 4'd0};
            dcnt_nxt = dcnt_r - dcnt_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt       = out_r;
    rcnt_nxt      = rcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (do_emit) begin
      rcnt_nxt              = (rcnt_r == 32'hFFFF_FFFF) ? rcnt_r : rcnt_r + 32'd1;
      out_valid_nxt         = 1'b1;
      out_nxt.character     = emit_chr;
      out_nxt.last_char     = (cw.act == A_EMIT_DIG) && (dcnt_r == dcnt_t'(1));
      out_nxt.running_count = rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rcnt_r      <= '0;
      dcnt_r      <= dcnt_t'(1);
      bcnt_r      <= '0;
      is_ptr_r    <= 1'b0;
      is_dec_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rcnt_r      <= rcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      is_ptr_r    <= is_ptr_nxt;
      is_dec_r    <= is_dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    upper_r <= upper_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r >= $past(rcnt_r))
    else $error("character count went backwards");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= dcnt_t'(HEX_DIGITS_PTR))
    else $error("digit counter out of range");

  a_no_partial_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(out_valid_r && !out_r.last_char))
    else $error("new value taken while a run is unfinished");
`endif

endmodule

@@ hw/rtl/integer_to_ascii_formatter.sv @@
// Each transferred value is formatted by the microcode program: pointer mode emits
// the 0x prefix, decimal runs a 32-step double-dabble loop, then all formats skip
// leading zero digits but the last. A new value is taken only after the last character
// of the previous one has been emitted. Digits leave the shift register one per
// cycle while the output is not stalled.
// Reset (rst_n low, synchronous) clears the step counter, output valid and the count.
module integer_to_ascii_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ifmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ifmt_pkg::out_item_t out_data
);
  import ifmt_pkg::*;

  cw_t   cw;
  stat_t stat;
  logic  accept;

  assign in_stall = !cw.take;
  assign accept   = in_valid && cw.take;

  ifmt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cw       (cw)
  );

  ifmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw        (cw),
    .accept    (accept),
    .in_item   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

@@ test/integer_to_ascii_formatter_tb.sv @@
// Testbench for integer_to_ascii_formatter: drives format/value transfers,
// predicts the emitted ASCII text and running count, checks every character.
// Depends on ifmt_pkg and the integer_to_ascii_formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import ifmt_pkg::*;

  localparam int          IDLE_PCT    = 18;
  localparam int          HOLD_CYCLES = 400;
  localparam int          STALL_LIMIT = 3000;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          MAX_REPORTS = 40;
  localparam logic [7:0]  CHR_LA      = 8'h61;  // 'a'
  localparam logic [7:0]  CHR_UA      = 8'h41;  // 'A'
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  integer_to_ascii_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  out_item_t   pending_chars[$];
  logic [31:0] chars_total;
  int          errors;
  int          values_sent[4];
  int          chars_checked;
  int          finished_runs;
  int          stall_cycles;
  bit          tx_quiet;
  bit          rx_quiet;
  int          hold_reqs;
  int          holds_done;
  int          hold_left;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Appends the characters one value should produce, with the saturating count.
  function automatic void predict_text(input op_t op, input logic [63:0] v);
    logic [7:0]  text[$];
    logic [63:0] x;
    logic [31:0] d;
    logic [3:0]  nib;
    int          nd;
    out_item_t   ch;
    text = {};
    if (op == OP_PTR) begin
      text.push_back(CHR_ZERO);
      text.push_back(CHR_X);
      x = v & PTR_MASK;
    end else begin
      x = {32'd0, v[31:0]};
    end
    if (op == OP_DEC) begin
      d = v[31:0];
      do begin
        text.push_front(CHR_ZERO + 8'(d % 10));
        d = d / 10;
      end while (d != 0);
    end else begin
      nd = 1;
      for (int i = 0; i < 16; i++) begin
        if (x[4*i +: 4] != 4'd0) nd = i + 1;
      end
      for (int i = nd - 1; i >= 0; i--) begin
        nib = x[4*i +: 4];
        if (nib < 4'd10) text.push_back(CHR_ZERO + 8'(nib));
        else if (op == OP_UHEX) text.push_back(CHR_UA + 8'(nib - 4'd10));
        else text.push_back(CHR_LA + 8'(nib - 4'd10));
      end
    end
    foreach (text[k]) begin
      if (chars_total != COUNT_MAX) chars_total++;
      ch.character     = text[k];
      ch.last_char     = (k == text.size() - 1);
      ch.running_count = chars_total;
      pending_chars.push_back(ch);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Starts and ends on a falling edge; valid stays high between back-to-back items.
  task automatic send_value(input op_t op, input logic [63:0] v);
    int gap;
    gap = 0;
    if (!tx_quiet && $urandom_range(99, 0) < IDLE_PCT) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data.op    <= op;
    in_data.value <= v;
    do @(posedge clk); while (in_stall);
    predict_text(op, v);
    values_sent[op]++;
    @(negedge clk);
  endtask

  // Spread of magnitudes so the leading-zero count varies widely.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    if ($urandom_range(1, 0) == 1) v = v >> $urandom_range(63, 0);
    return v;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_value(op_t'($urandom_range(3, 0)), rand_value());
    end
  endtask

  task automatic test_directed();
    send_value(OP_PTR,  64'h0);
    send_value(OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
    send_value(OP_PTR,  64'h8000_0000_0000_0000);
    send_value(OP_PTR,  64'h0000_0001_0000_0000);
    send_value(OP_PTR,  64'h1);
    send_value(OP_LHEX, 64'h0);
    send_value(OP_LHEX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(OP_LHEX, 64'h1234_5678_0000_0000);  // only upper half set: prints 0
    send_value(OP_LHEX, 64'h0000_0000_00AB_CDEF);
    send_value(OP_UHEX, 64'h0);
    send_value(OP_UHEX, 64'hDEAD_BEEF_ABCD_EF01);
    send_value(OP_UHEX, 64'h0000_0000_0000_000F);
    send_value(OP_UHEX, 64'h0000_0000_0000_0010);
    send_value(OP_DEC,  64'h0);
    send_value(OP_DEC,  64'h0000_0000_FFFF_FFFF);
    send_value(OP_DEC,  64'hFFFF_FFFF_3B9A_CA00);  // 1000000000 with junk above
    send_value(OP_DEC,  64'h9);
    send_value(OP_DEC,  64'hA);
    send_value(OP_DEC,  64'h0000_0001_0000_0000);  // upper bits only: prints 0
    send_value(OP_PTR,  64'h0123_4567_89AB_CDEF);
  endtask

  task automatic test_random_idle();
    send_random(200);
  endtask

  task automatic test_full_rate();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_random(80);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Receiver holds off while values keep coming, so the block backs up its input.
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    hold_reqs++;
    send_random(40);
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_tail();
    send_random(80);
  endtask

  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h", out_data.character));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (want.last_char) finished_runs++;
        if (out_data.character !== want.character)
          report_mismatch($sformatf("character %h, want %h",
                                    out_data.character, want.character));
        if (out_data.last_char !== want.last_char)
          report_mismatch($sformatf("last_char %b, want %b",
                                    out_data.last_char, want.last_char));
        if (out_data.running_count !== want.running_count)
          report_mismatch($sformatf("running_count %0d, want %0d",
                                    out_data.running_count, want.running_count));
      end
    end
  end

  // Watchdog: too long with no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d characters outstanding",
               stall_cycles, pending_chars.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    chars_total   = '0;
    errors        = 0;
    chars_checked = 0;
    finished_runs = 0;
    stall_cycles  = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_reqs     = 0;
    holds_done    = 0;
    hold_left     = 0;
    foreach (values_sent[i]) values_sent[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_idle();
    test_full_rate();
    test_backpressure();
    test_random_tail();
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("values per format ptr/lhex/uhex/dec: %0d/%0d/%0d/%0d",
             values_sent[OP_PTR], values_sent[OP_LHEX], values_sent[OP_UHEX],
             values_sent[OP_DEC]);
    $display("%0d characters in %0d runs checked, incl. full-rate and long hold-off phases",
             chars_checked, finished_runs);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ifmt_pkg.sv
hw/rtl/ifmt_seq.sv
hw/rtl/ifmt_dp.sv
hw/rtl/integer_to_ascii_formatter.sv
test/integer_to_ascii_formatter_tb.sv
